>>> sv/art_pkg.sv
// ----------------------------------------------------------------------------
// art_pkg
// Shared types, constants and helpers of the acknowledgement retransmit
// tracker: slot entry layout, cell control word, result word and codes.
// ----------------------------------------------------------------------------
package art_pkg;

  localparam int unsigned SLOTS_DEF = 16;

  localparam logic [31:0] RETRY_INTERVAL_RST = 32'd5000;
  localparam logic [7:0]  MAX_RETRIES_RST    = 8'd6;

  // Configuration register indexes.
  localparam logic REG_RETRY_INTERVAL = 1'b0;
  localparam logic REG_MAX_RETRIES    = 1'b1;

  typedef enum logic [1:0] {
    CMD_SEND = 2'd0,
    CMD_ACK  = 2'd1,
    CMD_TICK = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    EV_TRANSMIT    = 3'd0,
    EV_RETRANSMIT  = 3'd1,
    EV_EXPIRED     = 3'd2,
    EV_ACK_MATCHED = 3'd3,
    EV_ACK_UNKNOWN = 3'd4,
    EV_UNTRACKED   = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_INSERT = 3'd1,
    OP_UPDATE = 3'd2,
    OP_DELETE = 3'd3,
    OP_ROTATE = 3'd4
  } cell_op_e;

  typedef struct packed {
    logic        valid;
    logic [15:0] key;
    logic [7:0]  kind;
    logic [7:0]  unit;
    logic [15:0] payload;
    logic [31:0] sent;
    logic [7:0]  count;
  } entry_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    cell_op_e    op;
    logic [15:0] key;
    entry_t      ins;
    entry_t      head;
  } cell_ctrl_t;

  typedef struct packed {
    event_e      ev;
    logic [15:0] key;
    logic [7:0]  kind;
    logic [7:0]  unit;
    logic [15:0] payload;
    logic [7:0]  attempt;
    logic        last;
  } result_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] c);
    return (c == 8'hFF) ? c : c + 8'd1;
  endfunction

endpackage

>>> sv/art_cell.sv
// ----------------------------------------------------------------------------
// art_cell
// One slot of the tracker chain. Holds a single entry and, on the broadcast
// operation, keeps or updates it, or takes a neighbor, insert or head entry.
// ----------------------------------------------------------------------------
module art_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  art_pkg::cell_ctrl_t ctrl_i,
  input  art_pkg::entry_t     left_i,
  input  logic                left_lt_i,
  input  art_pkg::entry_t     right_i,
  output art_pkg::entry_t     entry_o,
  output logic                lt_o,
  output logic                eq_o
);
  import art_pkg::*;

  entry_t ent_q, ent_d;

  assign lt_o    = ent_q.valid && (ent_q.key < ctrl_i.key);
  assign eq_o    = ent_q.valid && (ent_q.key == ctrl_i.key);
  assign entry_o = ent_q;

  // Valid entries sit in a packed prefix in ascending key order. Inserts
  // open a gap by shifting the larger keys right, deletes close it again.
  always_comb begin
    ent_d = ent_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (!lt_o) begin
          if (left_lt_i) begin
            ent_d = ctrl_i.ins;
          end else begin
            ent_d = left_i;
          end
        end
      end
      OP_UPDATE: begin
        if (eq_o) begin
          ent_d.payload = ctrl_i.ins.payload;
          ent_d.sent    = ctrl_i.ins.sent;
          ent_d.count   = sat_inc(ent_q.count);
        end
      end
      OP_DELETE: begin
        if (!lt_o) begin
          ent_d = right_i;
        end
      end
      OP_ROTATE: begin
        // The last valid cell takes the processed head word.
        if (right_i.valid) begin
          ent_d = right_i;
        end else if (ent_q.valid) begin
          ent_d = ctrl_i.head;
        end
      end
      default: begin
        ent_d = ent_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

endmodule

>>> sv/ack_retransmit_tracker_core.sv
// ----------------------------------------------------------------------------
// ack_retransmit_tracker_core
// Table of sends that wait for an acknowledgement, kept as a chain of slot
// cells sorted by key. Sends update or insert, acks delete, and a tick
// walks the chain in key order to retransmit or expire entries.
//
//   channel  signals                         direction  handshake
//   in       command/key/kind/unit/ref/now   input      in_valid_i/in_ready_o
//   out      event/key/kind/unit/ref/attempt output     out_valid_o/out_ready_i
//   cfg      cfg_idx_i/cfg_data_i            input      cfg_we_i
//
// A send or ack is accepted and then handled in ST_EXEC, in which every
// cell compares its key at once and the chain shifts or updates.
// A tick walks the n pending entries; the chain rotates one slot a cycle,
// unless the output stalls, through cell 0, the only place an entry is judged.
// Reset empties the table and loads the register defaults.
// A full output register stalls the work until its word is taken; a new
// input word is accepted as soon as the previous one is finished.
// ----------------------------------------------------------------------------
module ack_retransmit_tracker_core #(
  parameter int unsigned Slots = art_pkg::SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] key_i,
  input  logic [7:0]  entry_kind_i,
  input  logic [7:0]  data_unit_i,
  input  logic [15:0] payload_ref_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_res_o,
  output logic [15:0] out_key_o,
  output logic [7:0]  out_kind_o,
  output logic [7:0]  out_unit_o,
  output logic [15:0] out_payload_ref_o,
  output logic [7:0]  attempt_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import art_pkg::*;

  localparam int unsigned CntW = $clog2(Slots + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [31:0] retry_q;
  logic [7:0]  maxr_q;

  logic [1:0]  cmd_q;
  logic [15:0] key_q;
  logic [7:0]  kind_q;
  logic [7:0]  unit_q;
  logic [15:0] pay_q;
  logic [31:0] now_q;

  logic [CntW-1:0] n_q, n_d;
  logic [CntW-1:0] rem_q, rem_d;

  logic    out_vld_q;
  result_t out_q, out_d;
  logic    out_load;
  logic    out_free;

  logic    pend_vld_q, pend_vld_d;
  result_t pend_q, pend_d;

  cell_ctrl_t       ctrl;
  cell_op_e         cell_op;
  entry_t           ent [Slots];
  logic [Slots-1:0] lt_v;
  logic [Slots-1:0] eq_v;
  logic [Slots-1:0] vld_v;

  entry_t hit_ent;
  logic   hit_any;
  logic   full;

  entry_t      head;
  entry_t      head_proc;
  logic [31:0] elapsed;
  logic        retx;
  logic        expire;
  result_t     scan_res;

  // --------------------------------------------------------------------------
  // Cell chain
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < Slots; i++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    logic   left_lt;

    if (i == 0) begin : g_first
      assign left_ent = '0;
      assign left_lt  = 1'b1;
    end else begin : g_inner
      assign left_ent = ent[i-1];
      assign left_lt  = lt_v[i-1];
    end

    if (i == Slots - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_mid
      assign right_ent = ent[i+1];
    end

    art_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .left_i    (left_ent),
      .left_lt_i (left_lt),
      .right_i   (right_ent),
      .entry_o   (ent[i]),
      .lt_o      (lt_v[i]),
      .eq_o      (eq_v[i])
    );

    assign vld_v[i] = ent[i].valid;
  end

  // Keys are unique, so at most one cell reports a match.
  always_comb begin
    hit_ent = '0;
    for (int i = 0; i < Slots; i++) begin
      if (eq_v[i]) begin
        hit_ent = hit_ent | ent[i];
      end
    end
  end

  assign hit_any = |eq_v;
  assign full    = ent[Slots-1].valid;
  assign head    = ent[0];

  // --------------------------------------------------------------------------
  // Judgement of the head entry during a tick
  // --------------------------------------------------------------------------
  assign elapsed = now_q - head.sent;
  assign retx    = head.valid && (elapsed >= retry_q) && (head.count < maxr_q);
  assign expire  = head.valid && (head.count >= maxr_q);

  always_comb begin
    head_proc = head;
    if (retx) begin
      head_proc.sent  = now_q;
      head_proc.count = sat_inc(head.count);
    end
    if (expire) begin
      head_proc.valid = 1'b0;
    end
    scan_res.ev      = retx ? EV_RETRANSMIT : EV_EXPIRED;
    scan_res.key     = head_proc.key;
    scan_res.kind    = head_proc.kind;
    scan_res.unit    = head_proc.unit;
    scan_res.payload = head_proc.payload;
    scan_res.attempt = head_proc.count;
    scan_res.last    = 1'b0;
  end

  assign ctrl.op   = cell_op;
  assign ctrl.key  = key_q;
  assign ctrl.ins  = '{valid: 1'b1, key: key_q, kind: kind_q, unit: unit_q,
                       payload: pay_q, sent: now_q, count: 8'd1};
  assign ctrl.head = head_proc;

  assign out_free   = !out_vld_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    cell_op    = OP_HOLD;
    out_load   = 1'b0;
    out_d      = pend_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    rem_d      = rem_q;
    n_d        = n_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (cmd_e'(command_i))
            CMD_SEND, CMD_ACK: begin
              state_d = ST_EXEC;
            end
            CMD_TICK: begin
              state_d = ST_SCAN;
              rem_d   = n_q;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_EXEC: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          out_d    = '{ev: EV_TRANSMIT, key: key_q, kind: kind_q, unit: unit_q,
                       payload: pay_q, attempt: 8'd1, last: 1'b1};
          if (cmd_q == CMD_SEND) begin
            if (hit_any) begin
              cell_op         = OP_UPDATE;
              out_d.key       = hit_ent.key;
              out_d.kind      = hit_ent.kind;
              out_d.unit      = hit_ent.unit;
              out_d.attempt   = sat_inc(hit_ent.count);
            end else if (!full) begin
              cell_op = OP_INSERT;
              n_d     = n_q + CntW'(1);
            end else begin
              out_d.ev      = EV_UNTRACKED;
              out_d.attempt = 8'd0;
            end
          end else begin
            if (hit_any) begin
              cell_op       = OP_DELETE;
              n_d           = n_q - CntW'(1);
              out_d.ev      = EV_ACK_MATCHED;
              out_d.key     = hit_ent.key;
              out_d.kind    = hit_ent.kind;
              out_d.unit    = hit_ent.unit;
              out_d.payload = hit_ent.payload;
              out_d.attempt = hit_ent.count;
            end else begin
              out_d.ev      = EV_ACK_UNKNOWN;
              out_d.kind    = 8'd0;
              out_d.unit    = 8'd0;
              out_d.payload = 16'd0;
              out_d.attempt = 8'd0;
            end
          end
        end
      end

      ST_SCAN: begin
        // A result is held back one step so that the final one can be
        // marked as last once the walk is over.
        if (rem_q == '0) begin
          state_d = ST_FLUSH;
        end else if (!(retx || expire) || !pend_vld_q || out_free) begin
          cell_op = OP_ROTATE;
          rem_d   = rem_q - CntW'(1);
          if (retx || expire) begin
            if (pend_vld_q) begin
              out_load = 1'b1;
            end
            pend_d     = scan_res;
            pend_vld_d = 1'b1;
          end
          if (expire) begin
            n_d = n_q - CntW'(1);
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_load   = 1'b1;
          out_d.last = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      n_q        <= '0;
      rem_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      n_q        <= n_d;
      rem_q      <= rem_d;
      pend_vld_q <= pend_vld_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (out_load) begin
      out_q <= out_d;
    end
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= command_i;
      key_q  <= key_i;
      kind_q <= entry_kind_i;
      unit_q <= data_unit_i;
      pay_q  <= payload_ref_i;
      now_q  <= now_ms_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_q <= RETRY_INTERVAL_RST;
      maxr_q  <= MAX_RETRIES_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RETRY_INTERVAL: retry_q <= cfg_data_i;
        REG_MAX_RETRIES:    maxr_q  <= cfg_data_i[7:0];
        default: begin
          retry_q <= retry_q;
        end
      endcase
    end
  end

  assign out_valid_o       = out_vld_q;
  assign event_res_o       = out_q.ev;
  assign out_key_o         = out_q.key;
  assign out_kind_o        = out_q.kind;
  assign out_unit_o        = out_q.unit;
  assign out_payload_ref_o = out_q.payload;
  assign attempt_o         = out_q.attempt;
  assign last_o            = out_q.last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CntW'(Slots))
    else $error("entry count exceeds the number of slots");

  a_packed_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld_v >> 1) & ~vld_v) == '0)
    else $error("valid entries do not form a packed prefix");

  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld_v) == int'(n_q))
    else $error("entry count disagrees with the valid cells");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_vld_q)
    else $error("held tick result left behind in idle");

  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && out_free) |=> (out_vld_q && out_q.last))
    else $error("send or ack finished without a final result");

endmodule
